### src/mas_pkg.sv
// ----------------------------------------------------------------------------
// mas_pkg: shared types and constants for the MPEG audio stream sniffer
// Header layout, tag and sync codes, frame kind codes and beat/verdict types.
// ----------------------------------------------------------------------------
`default_nettype none

package mas_pkg;

	// header gathered before each check
	localparam int HDR_LEN = 10;

	// tag marker bytes "ID3"
	localparam logic [7:0] TAG_ID0 = 8'h49;
	localparam logic [7:0] TAG_ID1 = 8'h44;
	localparam logic [7:0] TAG_ID2 = 8'h33;

	// footer-present flag in header byte 5, and the footer length added
	localparam logic [7:0]  TAG_FOOTER_FLAG = 8'h10;
	localparam logic [29:0] TAG_FOOTER_LEN  = 30'd10;

	// frame sync
	localparam logic [7:0] SYNC_BYTE = 8'hFF;
	localparam logic [7:0] SYNC_MASK = 8'hFE;
	localparam logic [7:0] SYNC_V1L3 = 8'hFA;
	localparam logic [7:0] SYNC_V1L2 = 8'hFC;
	localparam logic [7:0] SYNC_V2L3 = 8'hF2;
	localparam logic [7:0] SYNC_V2L2 = 8'hF4;
	localparam logic [7:0] SYNC_V2AAC = 8'hF8;
	localparam logic [7:0] SYNC_V4AAC = 8'hF0;

	// frame kind codes
	localparam logic [2:0] KIND_NONE  = 3'd0;
	localparam logic [2:0] KIND_V1L3  = 3'd1;
	localparam logic [2:0] KIND_V1L2  = 3'd2;
	localparam logic [2:0] KIND_V2L3  = 3'd3;
	localparam logic [2:0] KIND_V2L2  = 3'd4;
	localparam logic [2:0] KIND_V2AAC = 3'd5;
	localparam logic [2:0] KIND_V4AAC = 3'd6;

	// one input beat
	typedef struct packed {
		logic [7:0] data;
		logic       eos;
	} beat_t;

	// verdict produced by the core for one beat
	typedef struct packed {
		logic       hit;
		logic       accepted;
		logic [2:0] kind;
	} verdict_t;

	// map first two header bytes to a frame kind
	function automatic logic [2:0] sync_kind(input logic [7:0] b0, input logic [7:0] b1);
		logic [7:0] code;
		logic [2:0] kind;
		code = b1 & SYNC_MASK;
		unique case (code)
			SYNC_V1L3:  kind = KIND_V1L3;
			SYNC_V1L2:  kind = KIND_V1L2;
			SYNC_V2L3:  kind = KIND_V2L3;
			SYNC_V2L2:  kind = KIND_V2L2;
			SYNC_V2AAC: kind = KIND_V2AAC;
			SYNC_V4AAC: kind = KIND_V4AAC;
			default:    kind = KIND_NONE;
		endcase
		if (b0 != SYNC_BYTE) begin
			kind = KIND_NONE;
		end
		return kind;
	endfunction

endpackage

`default_nettype wire

### src/mas_in_reg.sv
// ----------------------------------------------------------------------------
// mas_in_reg: input register stage
// Captures one beat per cycle while not stalled and holds it until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mas_in_reg (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire logic [7:0]     data_byte,
	input  wire logic           end_of_stream,
	input  wire logic           advance,
	output logic                valid_s1,
	output mas_pkg::beat_t      beat_s1
);

	logic load;

	// stage is free when empty or being drained this cycle
	assign in_stall = valid_s1 && !advance;
	assign load     = in_valid && !in_stall;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			beat_s1.data <= data_byte;
			beat_s1.eos  <= end_of_stream;
		end
	end

endmodule

`default_nettype wire

### src/mas_core.sv
// ----------------------------------------------------------------------------
// mas_core: header gather, tag skip and sync verdict
// Per-beat state update; the verdict is combinational on the stage-1 beat.
// ----------------------------------------------------------------------------
`default_nettype none

module mas_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           advance,
	input  wire mas_pkg::beat_t beat_s1,
	output mas_pkg::verdict_t   verdict
);

	localparam logic [1:0] PH_GATHER = 2'd0;
	localparam logic [1:0] PH_SKIP   = 2'd1;
	localparam logic [1:0] PH_DONE   = 2'd2;
	localparam logic [1:0] PH_SPARE  = 2'd3;

	localparam logic [3:0] CNT_LEN  = 4'(mas_pkg::HDR_LEN);
	localparam logic [3:0] CNT_LAST = 4'(mas_pkg::HDR_LEN - 1);

	// header bytes 0..len-2; the last byte is the current beat
	logic [7:0]  hdr_q [mas_pkg::HDR_LEN-1];
	logic [3:0]  count_q, count_d, cnt;
	logic [29:0] skip_q, skip_d, skip_dec;
	logic [1:0]  phase_q, phase_d;
	logic [29:0] tag_size;
	logic        is_tag;
	logic        pending;
	logic        hdr_wr;

	// tag size: 7 bits per place, OR-ed unmasked, plus optional footer
	always_comb begin
		tag_size = {1'b0, hdr_q[6], 21'b0} | {8'b0, hdr_q[7], 14'b0} |
			{15'b0, hdr_q[8], 7'b0} | {22'b0, beat_s1.data};
		if ((hdr_q[5] & mas_pkg::TAG_FOOTER_FLAG) == mas_pkg::TAG_FOOTER_FLAG) begin
			tag_size = tag_size + mas_pkg::TAG_FOOTER_LEN;
		end
	end

	assign is_tag = (hdr_q[0] == mas_pkg::TAG_ID0) && (hdr_q[1] == mas_pkg::TAG_ID1) &&
		(hdr_q[2] == mas_pkg::TAG_ID2);
	assign cnt      = (count_q >= CNT_LEN) ? 4'd0 : count_q;
	assign skip_dec = (skip_q != 30'd0) ? skip_q - 30'd1 : skip_q;

	// next state and verdict
	always_comb begin
		count_d = count_q;
		skip_d  = skip_q;
		phase_d = phase_q;
		hdr_wr  = 1'b0;
		verdict = '0;
		pending = (phase_q == PH_GATHER) || (phase_q == PH_SKIP);
		unique case (phase_q)
			PH_GATHER: begin
				if (cnt == CNT_LAST) begin
					count_d = 4'd0;
					if (is_tag) begin
						if (tag_size == 30'd0) begin
							verdict.hit = 1'b1;
							phase_d     = PH_DONE;
						end else begin
							skip_d  = tag_size;
							phase_d = PH_SKIP;
						end
					end else begin
						verdict.hit  = 1'b1;
						verdict.kind = mas_pkg::sync_kind(hdr_q[0], hdr_q[1]);
						phase_d      = PH_DONE;
					end
				end else begin
					hdr_wr  = 1'b1;
					count_d = cnt + 4'd1;
				end
			end
			PH_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 30'd0) begin
					phase_d = PH_GATHER;
				end
			end
			PH_DONE, PH_SPARE: begin
				phase_d = phase_q;
			end
			default: begin
				phase_d = PH_GATHER;
			end
		endcase
		// last byte: reject if still undecided, then re-arm
		if (beat_s1.eos) begin
			if (pending && !verdict.hit) begin
				verdict.hit  = 1'b1;
				verdict.kind = mas_pkg::KIND_NONE;
			end
			count_d = 4'd0;
			skip_d  = 30'd0;
			phase_d = PH_GATHER;
		end
		verdict.accepted = (verdict.kind != mas_pkg::KIND_NONE);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 4'd0;
			skip_q  <= 30'd0;
			phase_q <= PH_GATHER;
		end else if (advance) begin
			count_q <= count_d;
			skip_q  <= skip_d;
			phase_q <= phase_d;
		end
	end

	// header store
	always_ff @(posedge clk) begin
		if (advance && hdr_wr) begin
			hdr_q[cnt] <= beat_s1.data;
		end
	end

endmodule

`default_nettype wire

### src/mpeg_audio_stream_sniffer.sv
// ----------------------------------------------------------------------------
// mpeg_audio_stream_sniffer: ID3v2 tag skip and MPEG/AAC sync detect
//
// Input channel: one file byte per beat (data_byte, end_of_stream) on
// in_valid / in_stall. Output channel: one verdict beat (accepted,
// frame_kind) on out_valid / out_stall, at most one per input byte.
// The block gathers a 10-byte header; a nonzero-size ID3 tag header makes
// it skip the tag and gather again, a zero-size one gives a rejection, any
// other header gives the verdict. A stream that ends undecided gives a
// rejection on its last byte; bytes after a verdict give nothing, and the
// last byte re-arms the block for a new file. Throughput: one byte per
// cycle while out_stall holds no pending verdict. The deciding byte is
// held in the input register, then its verdict beat in the result register.
// Reset clears the pipeline and returns to header gathering.
// When out_stall holds a pending verdict, the byte in the input register
// waits and in_stall rises until the verdict is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mpeg_audio_stream_sniffer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_stream,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            accepted,
	output logic [2:0]      frame_kind
);

	logic              valid_s1;
	mas_pkg::beat_t    beat_s1;
	mas_pkg::verdict_t verdict;
	logic              advance;
	logic              out_valid_s2;
	logic              accepted_s2;
	logic [2:0]        kind_s2;

	// stage 1 moves on unless a held verdict blocks the result register
	assign advance = valid_s1 && !(out_valid_s2 && out_stall);

	mas_in_reg u_in_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.advance       (advance),
		.valid_s1      (valid_s1),
		.beat_s1       (beat_s1)
	);

	mas_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.beat_s1 (beat_s1),
		.verdict (verdict)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance && verdict.hit) begin
			out_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance && verdict.hit) begin
			accepted_s2 <= verdict.accepted;
			kind_s2     <= verdict.kind;
		end
	end

	assign out_valid  = out_valid_s2;
	assign accepted   = accepted_s2;
	assign frame_kind = kind_s2;

endmodule

`default_nettype wire
